@@ src/assert_macros.svh @@
// Assertion macros shared by the mapper RTL.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define VM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check an implication that must hold at the next edge.
`define VM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ src/vmlcm_pkg.sv @@
// Shared types, command codes and color tables of the VU meter LED color mapper.
// No dependencies.
package vmlcm_pkg;

	localparam int unsigned PtrW = 4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  led_index;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       color_valid;
	} rsp_t;

	localparam logic [2:0] MODE_GRAD  = 3'd0;
	localparam logic [2:0] MODE_BANDS = 3'd1;
	localparam logic [2:0] MODE_PAL   = 3'd2;
	localparam logic [2:0] MODE_RBA   = 3'd3;
	localparam logic [2:0] MODE_RBB   = 3'd4;

	localparam logic [2:0] KIND_GRAD  = 3'd0;
	localparam logic [2:0] KIND_BANDS = 3'd1;
	localparam logic [2:0] KIND_PAL   = 3'd2;
	localparam logic [2:0] KIND_RBA   = 3'd3;
	localparam logic [2:0] KIND_RBB   = 3'd4;
	localparam logic [2:0] KIND_NONE  = 3'd5;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] idx;
	} cmd_t;

	// Rainbow state visible to the top level.
	typedef struct packed {
		logic [PtrW-1:0] offset;
		logic [PtrW-1:0] pointer;
	} rb_status_t;

	localparam rsp_t NoColor = '{red: 8'd0, green: 8'd0, blue: 8'd0, color_valid: 1'b0};

	function automatic rsp_t mk(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		rsp_t c;
		c.red = r;
		c.green = g;
		c.blue = b;
		c.color_valid = 1'b1;
		return c;
	endfunction

	function automatic rsp_t gradient_color(input logic [5:0] n);
		logic [7:0] n8;
		rsp_t c;
		n8 = {2'b00, n};
		if (n <= 6'd1)
			c = mk(8'd0, 8'd255, 8'd0);
		else if (n <= 6'd4)
			c = mk(8'((n8 - 8'd1) * 8'd85), 8'd255, 8'd0);
		else if (n <= 6'd8)
			c = mk(8'd255, 8'(8'd255 - (n8 - 8'd4) * 8'd63), 8'd0);
		else if (n <= 6'd11)
			c = mk(8'd255, 8'd0, 8'((n8 - 8'd8) * 8'd85));
		else if (n <= 6'd14)
			c = mk(8'(8'd255 - (n8 - 8'd11) * 8'd85), 8'd0, 8'd255);
		else
			c = NoColor;
		return c;
	endfunction

	function automatic rsp_t bands_color(input logic [5:0] n);
		rsp_t c;
		if (n <= 6'd2)
			c = mk(8'd255 - 8'd255, 8'd255, 8'd0);
		else if (n <= 6'd5)
			c = mk(8'd255, 8'd255, 8'd0);
		else if (n <= 6'd8)
			c = mk(8'd255, 8'd0, 8'd0);
		else
			c = mk(8'd200, 8'd0, 8'd100);
		return c;
	endfunction

	function automatic rsp_t palette_color(input logic [5:0] n);
		rsp_t c;
		logic [2:0] k;
		k = (n < 6'd7) ? n[2:0] : 3'd7;
		case (k)
			3'd0: c = mk(8'd200, 8'd30, 8'd200);
			3'd1: c = mk(8'd0, 8'd0, 8'd255);
			3'd2: c = mk(8'd0, 8'd255, 8'd255);
			3'd3: c = mk(8'd0, 8'd255, 8'd0);
			3'd4: c = mk(8'd255, 8'd255, 8'd0);
			3'd5: c = mk(8'd255, 8'd0, 8'd0);
			3'd6: c = mk(8'd255, 8'd0, 8'd255);
			default: c = mk(8'd255, 8'd255, 8'd255);
		endcase
		return c;
	endfunction

	function automatic rsp_t rainbow_a_color(input logic [PtrW-1:0] p);
		rsp_t c;
		case (p)
			4'd0:  c = mk(8'd255, 8'd0, 8'd0);
			4'd1:  c = mk(8'd255, 8'd85, 8'd0);
			4'd2:  c = mk(8'd255, 8'd170, 8'd0);
			4'd3:  c = mk(8'd255, 8'd255, 8'd0);
			4'd4:  c = mk(8'd170, 8'd255, 8'd0);
			4'd5:  c = mk(8'd85, 8'd255, 8'd0);
			4'd6:  c = mk(8'd0, 8'd255, 8'd0);
			4'd7:  c = mk(8'd85, 8'd255, 8'd0);
			4'd8:  c = mk(8'd170, 8'd255, 8'd0);
			4'd9:  c = mk(8'd255, 8'd255, 8'd0);
			4'd10: c = mk(8'd255, 8'd170, 8'd0);
			4'd11: c = mk(8'd255, 8'd85, 8'd0);
			default: c = NoColor;
		endcase
		return c;
	endfunction

	function automatic rsp_t rainbow_b_color(input logic [PtrW-1:0] p);
		rsp_t c;
		case (p)
			4'd0:  c = mk(8'd0, 8'd255, 8'd0);
			4'd1:  c = mk(8'd128, 8'd255, 8'd0);
			4'd2:  c = mk(8'd255, 8'd255, 8'd0);
			4'd3:  c = mk(8'd255, 8'd128, 8'd0);
			4'd4:  c = mk(8'd255, 8'd0, 8'd0);
			4'd5:  c = mk(8'd255, 8'd0, 8'd128);
			4'd6:  c = mk(8'd255, 8'd0, 8'd255);
			4'd7:  c = mk(8'd128, 8'd0, 8'd255);
			4'd8:  c = mk(8'd0, 8'd0, 8'd255);
			4'd9:  c = mk(8'd0, 8'd128, 8'd255);
			4'd10: c = mk(8'd0, 8'd255, 8'd255);
			4'd11: c = mk(8'd0, 8'd255, 8'd128);
			default: c = NoColor;
		endcase
		return c;
	endfunction

endpackage

@@ src/vmlcm_front.sv @@
// Front end: accepts requests, runs the rainbow timer and LED pointer, emits commands.
// Depends on vmlcm_pkg.
module vmlcm_front import vmlcm_pkg::*; #(
	parameter int PALETTE_LAST = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  req_t       req,
	input  logic [15:0] period,
	output cmd_t       cmd,
	output rb_status_t status
);

	localparam logic [PtrW-1:0] PalLast = PtrW'(PALETTE_LAST);

	logic [31:0]     last_step_q;
	logic [PtrW-1:0] offset_q;
	logic [PtrW-1:0] pointer_q;

	logic            is_rb;
	logic            reload;
	logic            advance;
	logic [31:0]     elapsed;
	logic [PtrW-1:0] offset_nxt;
	logic [PtrW-1:0] ptr_cur;

	always_comb begin
		is_rb = (req.mode == MODE_RBA) || (req.mode == MODE_RBB);
		reload = is_rb && (req.led_index == 6'd0);
		elapsed = req.now_ms - last_step_q;
		advance = reload && (elapsed > {16'd0, period});
		if (!advance)
			offset_nxt = offset_q;
		else if (offset_q >= PalLast)
			offset_nxt = '0;
		else
			offset_nxt = offset_q + 1'b1;
		ptr_cur = reload ? offset_nxt : pointer_q;
	end

	always_comb begin
		unique case (req.mode)
			MODE_GRAD:  cmd.kind = KIND_GRAD;
			MODE_BANDS: cmd.kind = KIND_BANDS;
			MODE_PAL:   cmd.kind = KIND_PAL;
			MODE_RBA:   cmd.kind = KIND_RBA;
			MODE_RBB:   cmd.kind = KIND_RBB;
			default:    cmd.kind = KIND_NONE;
		endcase
		cmd.idx = is_rb ? {2'b00, ptr_cur} : req.led_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_step_q <= '0;
			offset_q <= '0;
			pointer_q <= '0;
		end else if (accept && is_rb) begin
			if (advance)
				last_step_q <= req.now_ms;
			offset_q <= offset_nxt;
			pointer_q <= (ptr_cur != '0) ? ptr_cur - 1'b1 : PalLast;
		end
	end

	assign status.offset = offset_q;
	assign status.pointer = pointer_q;

endmodule

@@ src/vmlcm_queue.sv @@
// Two-entry command queue between front and back.
// Depends on vmlcm_pkg.
module vmlcm_queue import vmlcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic empty,
	output logic full,
	output logic [1:0] count
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign rdata = slot_q[rd_q];
	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'd2);
	assign count = count_q;

endmodule

@@ src/vmlcm_back.sv @@
// Back end: turns commands into colors and holds the result register.
// Depends on vmlcm_pkg.
module vmlcm_back import vmlcm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic valid_q;
	rsp_t rsp_q;
	rsp_t color;

	always_comb begin
		unique case (q_cmd.kind)
			KIND_GRAD:  color = gradient_color(q_cmd.idx);
			KIND_BANDS: color = bands_color(q_cmd.idx);
			KIND_PAL:   color = palette_color(q_cmd.idx);
			KIND_RBA:   color = rainbow_a_color(q_cmd.idx[PtrW-1:0]);
			KIND_RBB:   color = rainbow_b_color(q_cmd.idx[PtrW-1:0]);
			default:    color = NoColor;
		endcase
	end

	assign q_pop = !q_empty && (!valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (!rsp_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			rsp_q <= color;
	end

	assign rsp_valid = valid_q;
	assign rsp = rsp_q;

endmodule

@@ src/vu_meter_led_color_mapper.sv @@
// VU meter LED color mapper: one RGB color per requested LED.
// Request channel req/req_valid/req_stall, result channel rsp/rsp_valid/rsp_stall,
// APB register port holding step_period_ms at byte address 0 (reset 100).
// Each accepted request yields exactly one result, in order.
// Modes 0..2 pick fixed gradients, bands and palette colors by LED index;
// modes 3 and 4 read rainbow tables through a down-counting LED pointer,
// reloaded from a start offset on index 0. The offset advances once more
// than step_period_ms have passed since its last advance.
// Accepted requests are queued and popped to the result register unless it
// holds a stalled result. Throughput: one request per cycle while req_stall is
// low; the front updates the rainbow state in the accept cycle, a two-entry
// queue feeds the color lookup stage. req_stall rises only while the queue is
// full, i.e. when the receiver holds rsp_stall; the pending result stays on rsp
// unchanged while stalled. Reset clears the rainbow offset, LED pointer and step
// timestamp, empties the queue and drops rsp_valid; the period register returns to 100.
// Depends on vmlcm_pkg, vmlcm_front, vmlcm_queue, vmlcm_back, assert_macros.svh.
`include "assert_macros.svh"

module vu_meter_led_color_mapper import vmlcm_pkg::*; #(
	parameter int PALETTE_LAST = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [15:0] PeriodReset = 16'd100;

	logic [15:0] period_q;
	logic        accept;
	cmd_t        f_cmd;
	cmd_t        q_cmd;
	rb_status_t  rb_status;
	logic        q_empty;
	logic        q_full;
	logic        q_pop;
	logic [1:0]  q_count;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			period_q <= PeriodReset;
		else if (psel && penable && pwrite && pready && !paddr[2])
			period_q <= pwdata[15:0];
	end

	assign req_stall = q_full;
	assign accept = req_valid && !q_full;

	vmlcm_front #(.PALETTE_LAST(PALETTE_LAST)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.period (period_q),
		.cmd    (f_cmd),
		.status (rb_status)
	);

	vmlcm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (f_cmd),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty),
		.full   (q_full),
		.count  (q_count)
	);

	vmlcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	`VM_ASSERT_NEXT(a_beat_not_lost, req_valid && !req_stall, q_count != 2'd0, "beat lost")
	`VM_ASSERT(a_offset_range, rb_status.offset <= PtrW'(PALETTE_LAST), "rainbow offset out of range")
	`VM_ASSERT(a_pointer_range, rb_status.pointer <= PtrW'(PALETTE_LAST), "LED pointer out of range")
	`VM_ASSERT_NEXT(a_pop_loads_rsp, q_pop, rsp_valid, "popped command produced no result")

endmodule

@@ tb/vu_meter_led_color_mapper_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of vu_meter_led_color_mapper: a color tracker predicts each beat
// from the accepted requests while tasks drive requests, result stalls and the APB register.
// Depends on vmlcm_pkg and the mapper RTL.

import vmlcm_pkg::*;

class led_color_tracker;
	localparam logic [3:0] LAST_ENTRY = 4'd11;

	logic [15:0] period_ms;
	logic [31:0] last_step_ms;
	logic [3:0]  offset;
	logic [3:0]  pointer;
	rsp_t        expected_colors[$];
	int          mismatches;

	function new();
		period_ms = 16'd100;
		last_step_ms = '0;
		offset = '0;
		pointer = '0;
		mismatches = 0;
	endfunction

	function rsp_t lit(logic [23:0] rgb);
		return rsp_t'({rgb, 1'b1});
	endfunction

	function rsp_t gradient(logic [5:0] n);
		int k;
		k = n;
		if (k <= 1) return lit({8'd0, 8'd255, 8'd0});
		if (k <= 4) return lit({8'((k - 1) * 85), 8'd255, 8'd0});
		if (k <= 8) return lit({8'd255, 8'(255 - (k - 4) * 63), 8'd0});
		if (k <= 11) return lit({8'd255, 8'd0, 8'((k - 8) * 85)});
		if (k <= 14) return lit({8'(255 - (k - 11) * 85), 8'd0, 8'd255});
		return '0;
	endfunction

	function rsp_t bands(logic [5:0] n);
		if (n <= 6'd2) return lit(24'h00FF00);
		if (n <= 6'd5) return lit(24'hFFFF00);
		if (n <= 6'd8) return lit(24'hFF0000);
		return lit({8'd200, 8'd0, 8'd100});
	endfunction

	function rsp_t palette(logic [5:0] n);
		case ((n < 6'd7) ? n[2:0] : 3'd7)
			3'd0: return lit({8'd200, 8'd30, 8'd200});
			3'd1: return lit(24'h0000FF);
			3'd2: return lit(24'h00FFFF);
			3'd3: return lit(24'h00FF00);
			3'd4: return lit(24'hFFFF00);
			3'd5: return lit(24'hFF0000);
			3'd6: return lit(24'hFF00FF);
			default: return lit(24'hFFFFFF);
		endcase
	endfunction

	function logic [23:0] rainbow_rgb(bit table_b, logic [3:0] p);
		if (!table_b) begin
			case (p)
				4'd0:  return 24'hFF0000;
				4'd1:  return 24'hFF5500;
				4'd2:  return 24'hFFAA00;
				4'd3:  return 24'hFFFF00;
				4'd4:  return 24'hAAFF00;
				4'd5:  return 24'h55FF00;
				4'd6:  return 24'h00FF00;
				4'd7:  return 24'h55FF00;
				4'd8:  return 24'hAAFF00;
				4'd9:  return 24'hFFFF00;
				4'd10: return 24'hFFAA00;
				default: return 24'hFF5500;
			endcase
		end
		case (p)
			4'd0:  return 24'h00FF00;
			4'd1:  return 24'h80FF00;
			4'd2:  return 24'hFFFF00;
			4'd3:  return 24'hFF8000;
			4'd4:  return 24'hFF0000;
			4'd5:  return 24'hFF0080;
			4'd6:  return 24'hFF00FF;
			4'd7:  return 24'h8000FF;
			4'd8:  return 24'h0000FF;
			4'd9:  return 24'h0080FF;
			4'd10: return 24'h00FFFF;
			default: return 24'h00FF80;
		endcase
	endfunction

	function rsp_t rainbow(bit table_b, logic [5:0] n, logic [31:0] now);
		logic [31:0] elapsed;
		logic [3:0]  p;
		rsp_t        c;
		if (n == 6'd0) begin
			elapsed = now - last_step_ms;
			if (elapsed > {16'd0, period_ms}) begin
				last_step_ms = now;
				offset = (offset >= LAST_ENTRY) ? 4'd0 : offset + 4'd1;
			end
			pointer = offset;
		end
		p = pointer;
		if (p <= 4'd11)
			c = lit(rainbow_rgb(table_b, p));
		else
			c = '0;
		pointer = (p != 4'd0) ? p - 4'd1 : LAST_ENTRY;
		return c;
	endfunction

	function void note_request(req_t r);
		rsp_t c;
		case (r.mode)
			MODE_GRAD:  c = gradient(r.led_index);
			MODE_BANDS: c = bands(r.led_index);
			MODE_PAL:   c = palette(r.led_index);
			MODE_RBA:   c = rainbow(1'b0, r.led_index, r.now_ms);
			MODE_RBB:   c = rainbow(1'b1, r.led_index, r.now_ms);
			default:    c = '0;
		endcase
		expected_colors.push_back(c);
	endfunction

	function void compare(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function void check_color(rsp_t got);
		rsp_t want;
		if (expected_colors.size() == 0) begin
			$display("%0t: color beat with none expected, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = expected_colors.pop_front();
		compare("red", want.red, got.red);
		compare("green", want.green, got.green);
		compare("blue", want.blue, got.blue);
		compare("color_valid", {7'd0, want.color_valid}, {7'd0, got.color_valid});
	endfunction

	function int pending();
		return expected_colors.size();
	endfunction
endclass

module vu_meter_led_color_mapper_test;
	localparam logic [2:0] REG_STEP_PERIOD = 3'd0;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 150;
	localparam logic [5:0] GRAD_POINTS [8] = '{6'd0, 6'd2, 6'd5, 6'd9, 6'd12, 6'd14, 6'd15,
		6'd63};
	localparam logic [5:0] BAND_POINTS [5] = '{6'd2, 6'd3, 6'd6, 6'd9, 6'd63};
	localparam logic [5:0] PAL_POINTS [4] = '{6'd0, 6'd6, 6'd7, 6'd63};

	typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit          calm;
	bit          hold_req;
	int          hold_left;
	logic [31:0] ms_now;
	led_color_tracker colors;

	vu_meter_led_color_mapper u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) colors.note_request(req);
			if (rsp_valid && !rsp_stall) colors.check_color(rsp);
		end
	end

	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else
				rsp_stall = !calm && ($urandom_range(0, 99) < 30);
		end
	end

	initial begin
		#4_000_000;
		$display("vu_meter_led_color_mapper_test failed");
		$finish;
	end

	task automatic send(logic [2:0] mode, logic [5:0] idx, logic [31:0] now);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 30) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req.mode = mode;
		req.led_index = idx;
		req.now_ms = now;
		req_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!req_stall) break;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (colors.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_period(logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_STEP_PERIOD;
		pwdata = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		colors.period_ms = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic run_phase(int items, logic [15:0] period, pressure_t pressure);
		int         sent;
		int         first;
		int         len;
		bit         pressed;
		logic [2:0] mode;
		sent = 0;
		pressed = 1'b0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 25) begin
				send(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom());
				sent++;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: mode = MODE_RBA;
					3, 4, 5: mode = MODE_RBB;
					6:       mode = MODE_GRAD;
					7:       mode = MODE_BANDS;
					8:       mode = MODE_PAL;
					default: mode = 3'($urandom_range(MODE_RBB + 1, 7));
				endcase
				if ($urandom_range(0, 19) == 0)
					ms_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
				else
					ms_now += $urandom_range(0, 2 * period + 2);
				first = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : 0;
				len = $urandom_range(1, 16);
				for (int i = first; i < first + len && i < 64; i++) begin
					send(mode, 6'(i), ms_now);
					sent++;
				end
			end
			if (!pressed && sent >= items / 2) begin
				pressed = 1'b1;
				if (pressure == PRESS_HOLD)
					hold_req = 1'b1;
				else if (pressure == PRESS_PAUSE)
					drain();
			end
		end
		drain();
	endtask

	initial begin
		colors = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = REG_STEP_PERIOD;
		pwdata = '0;
		ms_now = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (GRAD_POINTS[i]) send(MODE_GRAD, GRAD_POINTS[i], 32'd0);
		foreach (BAND_POINTS[i]) send(MODE_BANDS, BAND_POINTS[i], 32'd0);
		foreach (PAL_POINTS[i]) send(MODE_PAL, PAL_POINTS[i], 32'd0);
		// advance on a huge gap, then hold across the time wrap, then advance again
		send(MODE_RBA, 6'd0, 32'hFFFF_FFFF);
		send(MODE_RBA, 6'd5, 32'd0);
		send(MODE_RBB, 6'd0, 32'd50);
		send(MODE_RBB, 6'd63, 32'd0);
		send(MODE_RBA, 6'd0, 32'd152);
		for (int m = MODE_RBB + 1; m < 8; m++) send(3'(m), 6'd0, 32'hFFFF_FFFF);
		drain();
		ms_now = 32'd152;

		write_period(16'd0);
		run_phase(PHASE_ITEMS, 16'd0, PRESS_HOLD);
		write_period(16'hFFFF);
		run_phase(PHASE_ITEMS, 16'hFFFF, PRESS_NONE);
		calm = 1'b1;
		write_period(16'd1);
		run_phase(PHASE_ITEMS, 16'd1, PRESS_PAUSE);
		calm = 1'b0;
		write_period(16'd100);
		run_phase(PHASE_ITEMS, 16'd100, PRESS_HOLD);
		begin
			logic [15:0] period;
			period = 16'($urandom_range(2, 400));
			write_period(period);
			run_phase(PHASE_ITEMS, period, PRESS_NONE);
		end

		if (colors.mismatches == 0)
			$display("vu_meter_led_color_mapper_test passed");
		else
			$display("vu_meter_led_color_mapper_test failed");
		$finish;
	end
endmodule
